>>> src/point_transform_perspective_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point transform
// Concurrent assertion wrappers. They compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef POINT_TRANSFORM_PERSPECTIVE_ASSERT_SVH
`define POINT_TRANSFORM_PERSPECTIVE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define PTP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point transform assertion failed");
// Next-cycle implication, disabled during reset.
`define PTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point transform assertion failed");
`else
`define PTP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/ptp_pkg.sv
// ----------------------------------------------------------------------------
// Point transform package
// Widths, register codes, payload types and reset values shared by the
// homogeneous point transform and its divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

  // Fixed-point format and datapath widths.
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RED_W     = SUM_W - FRAC_BITS;
  localparam int LANES     = 3;
  localparam int ROWS      = 4;
  localparam int COLS      = 4;

  // Configuration register file.
  localparam int REG_COUNT   = 8;
  localparam int REG_W       = 64;
  localparam int REG_SEL_LSB = 3;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int ADDR_W      = REG_SEL_LSB + REG_IDX_W;

  localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

  // Register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0_COLS01,
    REG_ROW0_COLS23,
    REG_ROW1_COLS01,
    REG_ROW1_COLS23,
    REG_ROW2_COLS01,
    REG_ROW2_COLS23,
    REG_ROW3_COLS01,
    REG_ROW3_COLS23
  } reg_idx_t;

  // Input point.
  typedef struct packed {
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;
  } point_t;

  // Transformed point.
  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     divided;
    logic                     saturated;
  } result_t;

  // Side information that rides along with the divider pipeline.
  typedef struct packed {
    logic [LANES-1:0]             neg;
    logic                         divide;
    logic                         sat;
    logic [LANES-1:0][DATA_W-1:0] raw;
  } div_tag_t;

  // Reset value of each register: the identity matrix.
  function automatic logic [REG_W-1:0] reset_value(input reg_idx_t idx);
    logic [REG_W-1:0] v;
    v = '0;
    case (idx)
      REG_ROW0_COLS01: v = {{DATA_W{1'b0}}, ONE_FX};
      REG_ROW1_COLS01: v = {ONE_FX, {DATA_W{1'b0}}};
      REG_ROW2_COLS23: v = {{DATA_W{1'b0}}, ONE_FX};
      REG_ROW3_COLS23: v = {ONE_FX, {DATA_W{1'b0}}};
      default:         v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/ptp_divider.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Three lanes share one divisor. Each stage resolves one quotient bit of
// the dividend {num, FRAC_BITS zeros}; a tag travels with every item.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_divider (
  input  wire logic                                             clk,
  input  wire logic                                             rst,
  input  wire logic                                             in_valid,
  input  wire logic [ptp_pkg::LANES-1:0][ptp_pkg::DATA_W-1:0]   num,
  input  wire logic [ptp_pkg::DATA_W-1:0]                       den,
  input  wire ptp_pkg::div_tag_t                                tag_in,
  output logic                                                  out_valid,
  output logic [ptp_pkg::LANES-1:0][ptp_pkg::NUM_W-1:0]         quo,
  output ptp_pkg::div_tag_t                                     tag_out
);
  import ptp_pkg::*;

  // Stage k holds the state after quotient bit k has been resolved.
  logic [NUM_W-1:0]                    vld;
  logic [LANES-1:0][DATA_W-1:0]        rem      [NUM_W];
  logic [LANES-1:0][NUM_W-1:0]         nq       [NUM_W];
  logic [DATA_W-1:0]                   dv       [NUM_W];
  div_tag_t                            tg       [NUM_W];

  logic [LANES-1:0][DATA_W-1:0]        src_rem  [NUM_W];
  logic [LANES-1:0][NUM_W-1:0]         src_nq   [NUM_W];
  logic [DATA_W-1:0]                   src_dv   [NUM_W];
  logic [LANES-1:0][DATA_W-1:0]        rem_next [NUM_W];
  logic [LANES-1:0][NUM_W-1:0]         nq_next  [NUM_W];

  // Stage sources: the ports for the first stage, the previous stage after.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      src_rem[0][l] = '0;
      src_nq[0][l]  = {num[l], {FRAC_BITS{1'b0}}};
    end
    src_dv[0] = den;
    for (int k = 1; k < NUM_W; k++) begin
      src_rem[k] = rem[k-1];
      src_nq[k]  = nq[k-1];
      src_dv[k]  = dv[k-1];
    end
  end

  // One trial subtraction per lane and stage.
  always_comb begin
    logic [DATA_W:0] trial;
    logic            ge;
    for (int k = 0; k < NUM_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = {src_rem[k][l], src_nq[k][l][NUM_W-1]};
        ge    = (trial >= {1'b0, src_dv[k]});
        if (ge) begin
          trial = trial - {1'b0, src_dv[k]};
        end
        rem_next[k][l] = trial[DATA_W-1:0];
        nq_next[k][l]  = {src_nq[k][l][NUM_W-2:0], ge};
      end
    end
  end

  // Valid bits shift with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NUM_W-2:0], in_valid};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tg[0] <= tag_in;
    for (int k = 1; k < NUM_W; k++) begin
      tg[k] <= tg[k-1];
    end
    for (int k = 0; k < NUM_W; k++) begin
      rem[k] <= rem_next[k];
      nq[k]  <= nq_next[k];
      dv[k]  <= src_dv[k];
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo       = nq[NUM_W-1];
  assign tag_out   = tg[NUM_W-1];

endmodule

`default_nettype wire

>>> src/point_transform_perspective.sv
// ----------------------------------------------------------------------------
// Homogeneous 4x4 point transform with perspective divide
// Multiplies [x y z 1] by the configured Q16.16 matrix, saturates the
// sums and divides x', y', z' by w' unless w' is zero or one.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                  Direction
//   point     start, busy, point                       in
//   result    done, result                             out
//   config    psel, penable, pwrite, paddr, pwdata,    APB
//             prdata, pready
//
// One point is accepted every clock cycle; busy is high only in reset.
// A result passes through the Q16.16 multiply, add, clamp and sign-handling
// stages, the restoring divider, which resolves one quotient bit per stage,
// and one output register.
// Reset clears the valid bits and loads the identity matrix.
// The receiver cannot stall, so the pipeline never holds.
//
`default_nettype none
`include "point_transform_perspective_assert.svh"

module point_transform_perspective (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire ptp_pkg::point_t               point,
  output logic                               done,
  output ptp_pkg::result_t                   result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ptp_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [ptp_pkg::REG_W-1:0]     pwdata,
  output logic [ptp_pkg::REG_W-1:0]          prdata,
  output logic                               pready
);
  import ptp_pkg::*;

  localparam int LATENCY = NUM_W + 6;
  localparam logic [NUM_W-1:0] LIM_POS = NUM_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(1) << (DATA_W - 1);
  localparam logic signed [DATA_W-1:0] MAX_FX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_FX = {1'b1, {(DATA_W-1){1'b0}}};

  logic accept;
  logic [REG_W-1:0] cfg [REG_COUNT];
  logic [REG_IDX_W-1:0] reg_sel;
  logic signed [DATA_W-1:0] coef [ROWS][COLS];
  logic signed [DATA_W-1:0] pt [LANES];

  logic                     s1_valid;
  logic signed [PROD_W-1:0] s1_prod [COLS][LANES];
  logic signed [DATA_W-1:0] s1_d    [COLS];
  logic                     s2_valid;
  logic signed [PAIR_W-1:0] s2_pa   [COLS];
  logic signed [PAIR_W-1:0] s2_pb   [COLS];
  logic                     s3_valid;
  logic signed [RED_W-1:0]  s3_red  [COLS];
  logic [COLS-1:0]          fits;
  logic                     s4_valid;
  logic signed [DATA_W-1:0] s4_r    [COLS];
  logic                     s4_sat;
  logic                     s5_valid;
  logic [LANES-1:0][DATA_W-1:0] s5_num;
  logic [DATA_W-1:0]        s5_den;
  div_tag_t                 s5_tag;

  logic                           dq_valid;
  logic [LANES-1:0][NUM_W-1:0]    dq_quo;
  div_tag_t                       dq_tag;
  result_t                        result_next;

  // Handshake: the pipeline never holds, it only waits out reset.
  assign busy   = rst;
  assign accept = start & ~busy;

  // Configuration registers over APB.
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:REG_SEL_LSB];
  assign prdata  = cfg[reg_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        cfg[i] <= reset_value(reg_idx_t'(i));
      end
    end else if (psel && penable && pwrite && pready) begin
      cfg[reg_sel] <= pwdata;
    end
  end

  // Coefficients: even column in the low half, odd column in the high half.
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        coef[r][c] = $signed(cfg[2*r + (c >> 1)][(c & 1)*DATA_W +: DATA_W]);
      end
    end
  end

  assign pt[0] = point.in_x;
  assign pt[1] = point.in_y;
  assign pt[2] = point.in_z;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // Stage 1: twelve products; stage 2: pair sums with the translation term.
  always_ff @(posedge clk) begin
    for (int c = 0; c < COLS; c++) begin
      for (int k = 0; k < LANES; k++) begin
        s1_prod[c][k] <= pt[k] * coef[k][c];
      end
      s1_d[c]  <= coef[ROWS-1][c];
      s2_pa[c] <= PAIR_W'(s1_prod[c][0]) + PAIR_W'(s1_prod[c][1]);
      s2_pb[c] <= PAIR_W'(s1_prod[c][2]) + (PAIR_W'(s1_d[c]) <<< FRAC_BITS);
    end
  end

  // Stage 3: exact sum, reduced by flooring away the fraction bits.
  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] sum;
    for (int c = 0; c < COLS; c++) begin
      sum       = SUM_W'(s2_pa[c]) + SUM_W'(s2_pb[c]);
      s3_red[c] <= sum[SUM_W-1:FRAC_BITS];
    end
  end

  // Stage 4: clamp each sum to the 32-bit range.
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      fits[c] = (s3_red[c][RED_W-1:DATA_W-1] == '0) ||
                (s3_red[c][RED_W-1:DATA_W-1] == '1);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < COLS; c++) begin
      if (fits[c]) begin
        s4_r[c] <= s3_red[c][DATA_W-1:0];
      end else begin
        s4_r[c] <= s3_red[c][RED_W-1] ? MIN_FX : MAX_FX;
      end
    end
    s4_sat <= ~&fits;
  end

  // Stage 5: divide decision on the clamped w', magnitudes and signs.
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      s5_num[l]     <= s4_r[l][DATA_W-1] ? DATA_W'(-s4_r[l]) : s4_r[l];
      s5_tag.neg[l] <= s4_r[l][DATA_W-1] ^ s4_r[COLS-1][DATA_W-1];
      s5_tag.raw[l] <= s4_r[l];
    end
    s5_den        <= s4_r[COLS-1][DATA_W-1] ? DATA_W'(-s4_r[COLS-1]) : s4_r[COLS-1];
    s5_tag.divide <= (s4_r[COLS-1] != '0) && (s4_r[COLS-1] != ONE_FX);
    s5_tag.sat    <= s4_sat;
  end

  // Perspective divide, one quotient bit per stage.
  ptp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .num       (s5_num),
    .den       (s5_den),
    .tag_in    (s5_tag),
    .out_valid (dq_valid),
    .quo       (dq_quo),
    .tag_out   (dq_tag)
  );

  // Quotient clamp, sign and pass-through selection.
  always_comb begin
    logic [NUM_W-1:0]  lim;
    logic [DATA_W-1:0] qc;
    logic [LANES-1:0]  qsat;
    logic [LANES-1:0][DATA_W-1:0] val;
    for (int l = 0; l < LANES; l++) begin
      lim     = dq_tag.neg[l] ? LIM_NEG : LIM_POS;
      qsat[l] = dq_quo[l] > lim;
      qc      = qsat[l] ? lim[DATA_W-1:0] : dq_quo[l][DATA_W-1:0];
      if (dq_tag.divide) begin
        val[l] = dq_tag.neg[l] ? DATA_W'(-qc) : qc;
      end else begin
        val[l] = dq_tag.raw[l];
      end
    end
    result_next.out_x     = val[0];
    result_next.out_y     = val[1];
    result_next.out_z     = val[2];
    result_next.divided   = dq_tag.divide;
    result_next.saturated = dq_tag.sat | (dq_tag.divide & (|qsat));
  end

  // Output register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Checks on pipeline timing and the divide path.
  `PTP_ASSERT_IMPLIES(a_result_latency, clk, rst, done, $past(accept, LATENCY))
  `PTP_ASSERT_IMPLIES(a_divide_den_nonzero, clk, rst, s5_valid && s5_tag.divide, s5_den != '0)
  `PTP_ASSERT_NEXT(a_w_clamp_flag, clk, rst, s3_valid && !fits[COLS-1], s4_sat)

endmodule

`default_nettype wire
